// ----- hdl/sos_pkg.sv -----
`default_nettype none

package sos_pkg;

   localparam int MAX_SPHERES = 1024;
   localparam int IDX_W       = $clog2(MAX_SPHERES);
   localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
   localparam int COORD_W     = 24;
   localparam int RAD_W       = 20;
   localparam int CSR_IDX_W   = 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_NO_RANK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BOX_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_SIZE = 1'd1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [RAD_W-1:0]   radius;
   } sphere_type;

   localparam int SPH_W = $bits(sphere_type);

   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic [RAD_W-1:0]   radius;
      logic               last_sphere;
      logic [9:0]         read_rank;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [10:0]        kept_count;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [COORD_W-1:0] out_z;
      logic [RAD_W-1:0]   out_radius;
      logic               kept;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/sphere_overlap_suppression.sv -----
`default_nettype none

// Loads are written straight into the sphere memory.
// The load that carries last_sphere keeps busy high while the batch of n spheres
// is processed: the suppression marks are cleared, the spheres are rank sorted
// (one radius read per cycle from the single read port of the sphere memory),
// then suppression takes each rank still kept at its turn and checks it against
// every later unsuppressed sphere (memory reads plus the three-stage overlap
// unit), skipping later suppressed ones. The kept count is given after that.
// A read is answered after the rank lookup and then the sphere memory lookup;
// a read of a rank not loaded is answered without either lookup.
// Each result is shown for one cycle on rsp_valid and cannot be held off.
// No clearing pass after reset.
module sphere_overlap_suppression import sos_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire req_type              req_item,
   output      logic                 rsp_valid,
   output      rsp_type              rsp_item,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata
);

   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001,
      S_CLR     = 16'h0002,
      S_SORT_I  = 16'h0004,
      S_SORT_I2 = 16'h0008,
      S_SORT_J  = 16'h0010,
      S_SORT_W  = 16'h0020,
      S_SUP_I   = 16'h0040,
      S_SUP_I2  = 16'h0080,
      S_SUP_I3  = 16'h0100,
      S_SUP_J1  = 16'h0200,
      S_SUP_J2  = 16'h0400,
      S_SUP_J3  = 16'h0800,
      S_SUP_JW  = 16'h1000,
      S_RD1     = 16'h2000,
      S_RD2     = 16'h4000,
      S_DONE    = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic               err_ff, err_in;
   logic [COORD_W-1:0] box_low_ff, box_size_ff;
   logic [CNT_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [IDX_W-1:0]   rank_cnt_ff, rank_cnt_in;
   logic [RAD_W-1:0]   r_i_ff, r_i_in;
   sphere_type         sph_i_ff, sph_i_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic               mark_hold_ff, mark_hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               sph_we;
   logic [IDX_W-1:0]   sph_waddr, sph_raddr;
   logic [SPH_W-1:0]   sph_wdata, sph_rbits;
   sphere_type         sph_rdata;
   logic               rank_we;
   logic [IDX_W-1:0]   rank_waddr, rank_raddr, rank_wdata, rank_rdata;
   logic               mark_we, mark_wdata, mark_rdata;
   logic [IDX_W-1:0]   mark_waddr, mark_raddr;
   logic               ovl_in_valid, ovl_valid, ovl_hit;

   logic [COORD_W:0]   box_top;
   logic               outside;
   logic [CNT_W-1:0]   base;
   logic               ahead;

   assign sph_rdata = sphere_type'(sph_rbits);
   assign box_top   = {1'b0, box_low_ff} + {1'b0, box_size_ff};

   function automatic logic out_of_box(input logic [COORD_W-1:0] c,
                                       input logic [COORD_W-1:0] lo,
                                       input logic [COORD_W:0]   top);
      return (c < lo) || ({1'b0, c} >= top);
   endfunction

   assign outside = out_of_box(req_item.pos_x, box_low_ff, box_top) ||
                    out_of_box(req_item.pos_y, box_low_ff, box_top) ||
                    out_of_box(req_item.pos_z, box_low_ff, box_top);
   assign base   = done_ff ? '0 : cnt_ff;
   assign ahead  = (sph_rdata.radius > r_i_ff) ||
                   ((sph_rdata.radius == r_i_ff) && (j_ff < i_ff));

   sos_ram #(.WIDTH(SPH_W), .DEPTH(MAX_SPHERES)) u_sph_ram (
      .clock(clock), .we(sph_we), .waddr(sph_waddr), .wdata(sph_wdata),
      .raddr(sph_raddr), .rdata(sph_rbits)
   );

   sos_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SPHERES)) u_rank_ram (
      .clock(clock), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
      .raddr(rank_raddr), .rdata(rank_rdata)
   );

   sos_ram #(.WIDTH(1), .DEPTH(MAX_SPHERES)) u_mark_ram (
      .clock(clock), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
      .raddr(mark_raddr), .rdata(mark_rdata)
   );

   sos_overlap u_overlap (
      .clock(clock), .reset(reset), .in_valid(ovl_in_valid),
      .sph_a(sph_i_ff), .sph_b(sph_rdata), .out_valid(ovl_valid), .hit(ovl_hit)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_cnt_in  = rank_cnt_ff;
      r_i_in       = r_i_ff;
      sph_i_in     = sph_i_ff;
      kept_in      = kept_ff;
      mark_hold_in = mark_hold_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      sph_we       = 1'b0;
      sph_waddr    = base[IDX_W-1:0];
      sph_wdata    = {req_item.pos_x, req_item.pos_y, req_item.pos_z, req_item.radius};
      sph_raddr    = i_ff[IDX_W-1:0];
      rank_we      = 1'b0;
      rank_waddr   = rank_cnt_ff;
      rank_wdata   = i_ff[IDX_W-1:0];
      rank_raddr   = i_ff[IDX_W-1:0];
      mark_we      = 1'b0;
      mark_waddr   = i_ff[IDX_W-1:0];
      mark_wdata   = 1'b0;
      mark_raddr   = i_ff[IDX_W-1:0];
      ovl_in_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_item.opcode == OP_LOAD) begin
                  done_in = 1'b0;
                  err_in  = err_ff | outside;
                  cnt_in  = base;
                  if (base < CNT_W'(MAX_SPHERES)) begin
                     sph_we = 1'b1;
                     cnt_in = base + CNT_W'(1);
                  end
                  if (req_item.last_sphere) begin
                     i_in     = '0;
                     kept_in  = '0;
                     state_in = S_CLR;
                  end
               end else if (!done_ff || ({1'b0, req_item.read_rank} >= cnt_ff)) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.status     = ST_NO_RANK;
               end else begin
                  rank_raddr = req_item.read_rank;
                  mark_raddr = req_item.read_rank;
                  state_in   = S_RD1;
               end
            end
         end
         S_CLR: begin
            mark_we = 1'b1;
            i_in    = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) == cnt_ff) begin
               i_in     = '0;
               state_in = S_SORT_I;
            end
         end
         S_SORT_I: begin
            state_in = S_SORT_I2;
         end
         S_SORT_I2: begin
            r_i_in      = sph_rdata.radius;
            sph_raddr   = '0;
            j_in        = '0;
            rank_cnt_in = '0;
            state_in    = S_SORT_J;
         end
         S_SORT_J: begin
            // read data belongs to j; next address already goes out
            sph_raddr   = IDX_W'(j_ff + CNT_W'(1));
            rank_cnt_in = rank_cnt_ff + IDX_W'(ahead);
            j_in        = j_ff + CNT_W'(1);
            if (j_ff + CNT_W'(1) == cnt_ff) begin
               state_in = S_SORT_W;
            end
         end
         S_SORT_W: begin
            rank_we = 1'b1;
            i_in    = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) == cnt_ff) begin
               i_in     = '0;
               state_in = S_SUP_I;
            end else begin
               state_in = S_SORT_I;
            end
         end
         S_SUP_I: begin
            state_in = S_SUP_I2;
         end
         S_SUP_I2: begin
            sph_raddr = rank_rdata;
            if (mark_rdata) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = (i_ff + CNT_W'(1) == cnt_ff) ? S_DONE : S_SUP_I;
            end else begin
               state_in = S_SUP_I3;
            end
         end
         S_SUP_I3: begin
            sph_i_in = sph_rdata;
            kept_in  = kept_ff + CNT_W'(1);
            j_in     = i_ff + CNT_W'(1);
            state_in = (i_ff + CNT_W'(1) == cnt_ff) ? S_DONE : S_SUP_J1;
         end
         S_SUP_J1: begin
            rank_raddr = j_ff[IDX_W-1:0];
            mark_raddr = j_ff[IDX_W-1:0];
            state_in   = S_SUP_J2;
         end
         S_SUP_J2, S_SUP_JW: begin
            sph_raddr = rank_rdata;
            if ((state_ff == S_SUP_J2 && !mark_rdata) ||
                (state_ff == S_SUP_JW && !ovl_valid)) begin
               state_in = (state_ff == S_SUP_J2) ? S_SUP_J3 : S_SUP_JW;
            end else begin
               if (state_ff == S_SUP_JW && ovl_hit) begin
                  mark_we    = 1'b1;
                  mark_waddr = j_ff[IDX_W-1:0];
                  mark_wdata = 1'b1;
               end
               if (j_ff + CNT_W'(1) == cnt_ff) begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = (i_ff + CNT_W'(1) == cnt_ff) ? S_DONE : S_SUP_I;
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = S_SUP_J1;
               end
            end
         end
         S_SUP_J3: begin
            ovl_in_valid = 1'b1;
            state_in     = S_SUP_JW;
         end
         S_RD1: begin
            sph_raddr    = rank_rdata;
            mark_hold_in = mark_rdata;
            state_in     = S_RD2;
         end
         S_RD2: begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.status     = err_ff ? ST_OUTSIDE : ST_OK;
            rsp_in.out_x      = sph_rdata.x;
            rsp_in.out_y      = sph_rdata.y;
            rsp_in.out_z      = sph_rdata.z;
            rsp_in.out_radius = sph_rdata.radius;
            rsp_in.kept       = !mark_hold_ff;
            state_in          = S_IDLE;
         end
         S_DONE: begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.status     = err_ff ? ST_OUTSIDE : ST_OK;
            rsp_in.kept_count = kept_ff;
            done_in           = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         err_ff       <= 1'b0;
         box_low_ff   <= '0;
         box_size_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_BOX_LOW:  box_low_ff  <= csr_wdata;
               REG_BOX_SIZE: box_size_ff <= csr_wdata;
            endcase
         end
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      rank_cnt_ff  <= rank_cnt_in;
      r_i_ff       <= r_i_in;
      sph_i_ff     <= sph_i_in;
      kept_ff      <= kept_in;
      mark_hold_ff <= mark_hold_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/sos_ram.sv -----
`default_nettype none

module sos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- hdl/sos_overlap.sv -----
`default_nettype none

module sos_overlap import sos_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire sphere_type sph_a,
   input  wire sphere_type sph_b,
   output      logic       out_valid,
   output      logic       hit
);

   logic [2:0]          vld_ff;
   logic [COORD_W-1:0]  dx_ff, dy_ff, dz_ff;
   logic [RAD_W:0]      rs_ff;
   logic [2*COORD_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [2*RAD_W+1:0]  rs2_ff;
   logic                hit_ff;
   logic [2*COORD_W+1:0] dsq;

   function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   assign dsq = {2'b00, sx_ff} + {2'b00, sy_ff} + {2'b00, sz_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      dx_ff  <= absdiff(sph_a.x, sph_b.x);
      dy_ff  <= absdiff(sph_a.y, sph_b.y);
      dz_ff  <= absdiff(sph_a.z, sph_b.z);
      rs_ff  <= {1'b0, sph_a.radius} + {1'b0, sph_b.radius};
      sx_ff  <= dx_ff * dx_ff;
      sy_ff  <= dy_ff * dy_ff;
      sz_ff  <= dz_ff * dz_ff;
      rs2_ff <= rs_ff * rs_ff;
      hit_ff <= dsq < {{(2*COORD_W - 2*RAD_W){1'b0}}, rs2_ff};
   end

   assign out_valid = vld_ff[2];
   assign hit       = hit_ff;

endmodule

`default_nettype wire

// ----- hdl/sos_checker.sv -----
`default_nettype none

module sos_checker import sos_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire req_type              req_item,
   input wire logic                 rsp_valid,
   input wire rsp_type              rsp_item
);

   logic load_mid;
   logic read_acc;

   assign load_mid = start && !busy && req_item.opcode == OP_LOAD && !req_item.last_sphere;
   assign read_acc = start && !busy && req_item.opcode == OP_READ;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not quiet after reset");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      load_mid |=> !rsp_valid && !busy)
      else $error("plain load transaction produced a result or stalled");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      read_acc |=> rsp_valid || busy)
      else $error("read transaction neither answered nor in progress");

   a_no_rank_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_NO_RANK |->
         rsp_item.kept_count == '0 && !rsp_item.kept && rsp_item.out_radius == '0)
      else $error("rank-not-loaded result carries data");

endmodule

bind sphere_overlap_suppression sos_checker u_sos_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
   import sos_pkg::*;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0] csr_wdata;

   sphere_overlap_suppression dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the block state
   logic [COORD_W-1:0] mdl_x [MAX_SPHERES];
   logic [COORD_W-1:0] mdl_y [MAX_SPHERES];
   logic [COORD_W-1:0] mdl_z [MAX_SPHERES];
   logic [RAD_W-1:0]   mdl_r [MAX_SPHERES];
   int unsigned        mdl_rank [MAX_SPHERES];
   bit                 mdl_removed [MAX_SPHERES];
   int unsigned        mdl_count;
   bit                 mdl_outside;
   bit                 mdl_done;
   logic [COORD_W-1:0] mdl_box_low;
   logic [COORD_W-1:0] mdl_box_size;

   rsp_type expected_rsp_q[$];
   int errors;
   bit idle_on;

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   function automatic bit coord_in_box(logic [COORD_W-1:0] c);
      logic [COORD_W:0] top;
      top = {1'b0, mdl_box_low} + {1'b0, mdl_box_size};
      return (c >= mdl_box_low) && ({1'b0, c} < top);
   endfunction

   function automatic logic [63:0] udiff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      return (a >= b) ? 64'(a - b) : 64'(b - a);
   endfunction

   function automatic bit spheres_touch(int unsigned p, int unsigned q);
      logic [63:0] dx, dy, dz, rs;
      dx = udiff(mdl_x[p], mdl_x[q]);
      dy = udiff(mdl_y[p], mdl_y[q]);
      dz = udiff(mdl_z[p], mdl_z[q]);
      rs = 64'(mdl_r[p]) + 64'(mdl_r[q]);
      return dx * dx + dy * dy + dz * dz < rs * rs;
   endfunction

   function automatic int unsigned sort_and_thin();
      int unsigned j, cur, kept_n;
      kept_n = 0;
      for (int unsigned i = 0; i < mdl_count; i++) begin
         cur = i;
         j = i;
         while (j > 0 && mdl_r[mdl_rank[j-1]] < mdl_r[cur]) begin
            mdl_rank[j] = mdl_rank[j-1];
            j--;
         end
         mdl_rank[j] = cur;
      end
      for (int unsigned i = 0; i < mdl_count; i++) mdl_removed[i] = 1'b0;
      for (int unsigned i = 0; i < mdl_count; i++) begin
         if (!mdl_removed[i]) begin
            kept_n++;
            for (int unsigned k = i + 1; k < mdl_count; k++)
               if (!mdl_removed[k] && spheres_touch(mdl_rank[i], mdl_rank[k]))
                  mdl_removed[k] = 1'b1;
         end
      end
      return kept_n;
   endfunction

   function automatic void predict_sphere_op(req_type it);
      rsp_type e;
      int unsigned idx;
      e = '0;
      if (it.opcode == OP_LOAD) begin
         if (mdl_done) begin
            mdl_done = 1'b0;
            mdl_count = 0;
            for (int i = 0; i < MAX_SPHERES; i++) mdl_removed[i] = 1'b0;
         end
         if (!coord_in_box(it.pos_x) || !coord_in_box(it.pos_y) || !coord_in_box(it.pos_z))
            mdl_outside = 1'b1;
         if (mdl_count < MAX_SPHERES) begin
            mdl_x[mdl_count] = it.pos_x;
            mdl_y[mdl_count] = it.pos_y;
            mdl_z[mdl_count] = it.pos_z;
            mdl_r[mdl_count] = it.radius;
            mdl_count++;
         end
         if (it.last_sphere) begin
            e.kept_count = 11'(sort_and_thin());
            mdl_done = 1'b1;
            e.status = mdl_outside ? ST_OUTSIDE : ST_OK;
            expected_rsp_q.push_back(e);
         end
      end else begin
         if (!mdl_done || it.read_rank >= mdl_count) begin
            e.status = ST_NO_RANK;
         end else begin
            idx = mdl_rank[it.read_rank];
            e.status = mdl_outside ? ST_OUTSIDE : ST_OK;
            e.out_x = mdl_x[idx];
            e.out_y = mdl_y[idx];
            e.out_z = mdl_z[idx];
            e.out_radius = mdl_r[idx];
            e.kept = !mdl_removed[it.read_rank];
         end
         expected_rsp_q.push_back(e);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t unexpected transaction: actual %h", $time, rsp_item);
            errors++;
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_item.status !== e.status || rsp_item.kept_count !== e.kept_count ||
                rsp_item.out_x !== e.out_x || rsp_item.out_y !== e.out_y ||
                rsp_item.out_z !== e.out_z || rsp_item.out_radius !== e.out_radius ||
                rsp_item.kept !== e.kept) begin
               $display("%0t mismatch: expected %h actual %h", $time, e, rsp_item);
               errors++;
            end
         end
      end
   end

   task automatic random_gap();
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // start stays high after the accept; the next gap or drain takes it down
   task automatic send_item(req_type it);
      random_gap();
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_sphere_op(it);
   endtask

   task automatic load_sphere(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                              logic [19:0] r, bit last);
      req_type it;
      it = '0;
      it.opcode = OP_LOAD;
      it.pos_x = x; it.pos_y = y; it.pos_z = z;
      it.radius = r;
      it.last_sphere = last;
      it.read_rank = 10'($urandom);
      send_item(it);
   endtask

   task automatic read_rank(logic [9:0] rk);
      req_type it;
      it = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom}));
      it.opcode = OP_READ;
      it.read_rank = rk;
      send_item(it);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while ((expected_rsp_q.size() != 0 || busy) && guard < 200000000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_BOX_LOW) mdl_box_low = val;
      else mdl_box_size = val;
      @(posedge clock);
   endtask

   function automatic logic [23:0] rnd_coord();
      unique case ($urandom_range(0, 3))
         0: return 24'($urandom_range(0, 4095));
         1: return 24'hFFFFFF - 24'($urandom_range(0, 4095));
         default: return 24'($urandom);
      endcase
   endfunction

   // reads back every rank of the batch plus one past the end
   task automatic read_all(int unsigned n);
      for (int unsigned i = 0; i <= n && i < 1024; i++) read_rank(10'(i));
   endtask

   task automatic test_directed();
      read_rank(10'd0);                          // nothing loaded yet
      load_sphere(24'd0, 24'd0, 24'd0, 20'hFFFFF, 1'b0);
      load_sphere(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 1'b0);
      load_sphere(24'd100, 24'd100, 24'd100, 20'd0, 1'b0);
      load_sphere(24'd100, 24'd100, 24'd100, 20'd0, 1'b0);   // zero radii never touch
      load_sphere(24'd200, 24'd100, 24'd100, 20'd50, 1'b0);
      load_sphere(24'd300, 24'd100, 24'd100, 20'd50, 1'b1);  // exactly touching: kept
      read_all(6);
      read_rank(10'h3FF);
      drain();
      load_sphere(24'd5000, 24'd5000, 24'd5000, 20'd10, 1'b1); // single sphere batch
      read_all(1);
      drain();
   endtask

   task automatic test_box();
      write_reg(REG_BOX_LOW, 24'h100000);
      write_reg(REG_BOX_SIZE, 24'h100000);
      load_sphere(24'h100000, 24'h1FFFFF, 24'h150000, 20'd5, 1'b0);
      load_sphere(24'h0FFFFF, 24'h150000, 24'h150000, 20'd5, 1'b0);  // below box
      load_sphere(24'h150000, 24'h200000, 24'h150000, 20'd5, 1'b1);  // at top edge
      read_all(3);
      drain();
      write_reg(REG_BOX_LOW, 24'hFFFFFF);
      write_reg(REG_BOX_SIZE, 24'hFFFFFF);      // top needs the 25th bit
      load_sphere(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'd1, 1'b1);
      read_all(1);
      drain();
      write_reg(REG_BOX_LOW, 24'd0);
      write_reg(REG_BOX_SIZE, 24'd1);
      load_sphere(24'd0, 24'd0, 24'd1, 20'd1, 1'b1);
      drain();
      write_reg(REG_BOX_LOW, 24'd0);
      write_reg(REG_BOX_SIZE, 24'hFFFFFF);
   endtask

   task automatic test_random_batches(int items);
      int sent, n, cluster;
      logic [23:0] bx, by, bz;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         cluster = $urandom_range(0, 2);
         bx = rnd_coord(); by = rnd_coord(); bz = rnd_coord();
         for (int i = 0; i < n; i++) begin
            if (cluster != 0)
               load_sphere(bx ^ 24'($urandom_range(0, 255)), by ^ 24'($urandom_range(0, 255)),
                           bz ^ 24'($urandom_range(0, 255)),
                           ($urandom_range(0, 1) ? 20'($urandom_range(0, 200)) : 20'($urandom)),
                           i == n - 1);
            else
               load_sphere(rnd_coord(), rnd_coord(), rnd_coord(), 20'($urandom), i == n - 1);
         end
         sent += n;
         for (int i = 0; i < n + 2; i++) begin
            read_rank($urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, n)));
            sent++;
         end
         if ($urandom_range(0, 7) == 0) begin
            drain();
            write_reg(REG_BOX_LOW, $urandom_range(0, 1) ? 24'd0 : 24'($urandom));
            write_reg(REG_BOX_SIZE, $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom) | 24'd1);
         end
      end
   endtask

   // fills the store past capacity, overflow loads are dropped
   task automatic test_full_store();
      drain();
      write_reg(REG_BOX_LOW, 24'd0);
      write_reg(REG_BOX_SIZE, 24'hFFFFFF);
      for (int i = 0; i < MAX_SPHERES + 2; i++)
         load_sphere(24'(i * 4096), 24'd0, 24'd0, 20'(i % 3), i == MAX_SPHERES + 1);
      read_rank(10'd0);
      read_rank(10'h3FF);
      read_rank(10'd517);
      drain();
   endtask

   initial begin
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      idle_on = 1'b1;
      mdl_box_low = '0;
      mdl_box_size = 24'hFFFFFF;
      mdl_count = 0;
      mdl_outside = 1'b0;
      mdl_done = 1'b0;
      for (int i = 0; i < MAX_SPHERES; i++) mdl_removed[i] = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_box();
      test_random_batches(180);
      idle_on = 1'b0;
      test_random_batches(60);
      test_full_store();
      drain();
      if (errors == 0 && expected_rsp_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #500000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
